[design/scti_pkg.sv]
// Package: quarter-wave sine ROM, widths and the types built on them.
`timescale 1ns / 1ps
package scti_pkg;
  localparam int AngleW  = 16;
  localparam int OutW    = 17;
  localparam int RomLast = 256;
  localparam int FracW   = 6;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [OutW-1:0]   trig_t;
  typedef logic [8:0]               rom_idx_t;
  typedef logic [FracW-1:0]         frac_t;

  // Quarter-wave sine in Q15, entries 0..256.
  function automatic logic [16:0] rom_entry(input rom_idx_t i);
    logic [16:0] r;
    case (i)
      9'd0: r = 17'h0000; 9'd1: r = 17'h00c9; 9'd2: r = 17'h0192; 9'd3: r = 17'h025b;
      9'd4: r = 17'h0324; 9'd5: r = 17'h03ed; 9'd6: r = 17'h04b6; 9'd7: r = 17'h057f;
      9'd8: r = 17'h0647; 9'd9: r = 17'h0710; 9'd10: r = 17'h07d9; 9'd11: r = 17'h08a2;
      9'd12: r = 17'h096a; 9'd13: r = 17'h0a33; 9'd14: r = 17'h0afb; 9'd15: r = 17'h0bc3;
      9'd16: r = 17'h0c8b; 9'd17: r = 17'h0d53; 9'd18: r = 17'h0e1b; 9'd19: r = 17'h0ee3;
      9'd20: r = 17'h0fab; 9'd21: r = 17'h1072; 9'd22: r = 17'h1139; 9'd23: r = 17'h1201;
      9'd24: r = 17'h12c8; 9'd25: r = 17'h138e; 9'd26: r = 17'h1455; 9'd27: r = 17'h151b;
      9'd28: r = 17'h15e2; 9'd29: r = 17'h16a8; 9'd30: r = 17'h176d; 9'd31: r = 17'h1833;
      9'd32: r = 17'h18f8; 9'd33: r = 17'h19bd; 9'd34: r = 17'h1a82; 9'd35: r = 17'h1b47;
      9'd36: r = 17'h1c0b; 9'd37: r = 17'h1ccf; 9'd38: r = 17'h1d93; 9'd39: r = 17'h1e56;
      9'd40: r = 17'h1f19; 9'd41: r = 17'h1fdc; 9'd42: r = 17'h209f; 9'd43: r = 17'h2161;
      9'd44: r = 17'h2223; 9'd45: r = 17'h22e5; 9'd46: r = 17'h23a6; 9'd47: r = 17'h2467;
      9'd48: r = 17'h2528; 9'd49: r = 17'h25e8; 9'd50: r = 17'h26a8; 9'd51: r = 17'h2767;
      9'd52: r = 17'h2826; 9'd53: r = 17'h28e5; 9'd54: r = 17'h29a3; 9'd55: r = 17'h2a61;
      9'd56: r = 17'h2b1f; 9'd57: r = 17'h2bdc; 9'd58: r = 17'h2c98; 9'd59: r = 17'h2d55;
      9'd60: r = 17'h2e11; 9'd61: r = 17'h2ecc; 9'd62: r = 17'h2f87; 9'd63: r = 17'h3041;
      9'd64: r = 17'h30fb; 9'd65: r = 17'h31b5; 9'd66: r = 17'h326e; 9'd67: r = 17'h3326;
      9'd68: r = 17'h33de; 9'd69: r = 17'h3496; 9'd70: r = 17'h354d; 9'd71: r = 17'h3604;
      9'd72: r = 17'h36ba; 9'd73: r = 17'h376f; 9'd74: r = 17'h3824; 9'd75: r = 17'h38d8;
      9'd76: r = 17'h398c; 9'd77: r = 17'h3a40; 9'd78: r = 17'h3af2; 9'd79: r = 17'h3ba5;
      9'd80: r = 17'h3c56; 9'd81: r = 17'h3d07; 9'd82: r = 17'h3db8; 9'd83: r = 17'h3e68;
      9'd84: r = 17'h3f17; 9'd85: r = 17'h3fc5; 9'd86: r = 17'h4073; 9'd87: r = 17'h4121;
      9'd88: r = 17'h41ce; 9'd89: r = 17'h427a; 9'd90: r = 17'h4325; 9'd91: r = 17'h43d0;
      9'd92: r = 17'h447a; 9'd93: r = 17'h4524; 9'd94: r = 17'h45cd; 9'd95: r = 17'h4675;
      9'd96: r = 17'h471c; 9'd97: r = 17'h47c3; 9'd98: r = 17'h4869; 9'd99: r = 17'h490f;
      9'd100: r = 17'h49b4; 9'd101: r = 17'h4a58; 9'd102: r = 17'h4afb; 9'd103: r = 17'h4b9e;
      9'd104: r = 17'h4c3f; 9'd105: r = 17'h4ce1; 9'd106: r = 17'h4d81; 9'd107: r = 17'h4e21;
      9'd108: r = 17'h4ebf; 9'd109: r = 17'h4f5e; 9'd110: r = 17'h4ffb; 9'd111: r = 17'h5097;
      9'd112: r = 17'h5133; 9'd113: r = 17'h51ce; 9'd114: r = 17'h5269; 9'd115: r = 17'h5302;
      9'd116: r = 17'h539b; 9'd117: r = 17'h5433; 9'd118: r = 17'h54ca; 9'd119: r = 17'h5560;
      9'd120: r = 17'h55f5; 9'd121: r = 17'h568a; 9'd122: r = 17'h571d; 9'd123: r = 17'h57b0;
      9'd124: r = 17'h5842; 9'd125: r = 17'h58d4; 9'd126: r = 17'h5964; 9'd127: r = 17'h59f3;
      9'd128: r = 17'h5a82; 9'd129: r = 17'h5b10; 9'd130: r = 17'h5b9d; 9'd131: r = 17'h5c29;
      9'd132: r = 17'h5cb4; 9'd133: r = 17'h5d3e; 9'd134: r = 17'h5dc7; 9'd135: r = 17'h5e50;
      9'd136: r = 17'h5ed7; 9'd137: r = 17'h5f5e; 9'd138: r = 17'h5fe3; 9'd139: r = 17'h6068;
      9'd140: r = 17'h60ec; 9'd141: r = 17'h616f; 9'd142: r = 17'h61f1; 9'd143: r = 17'h6271;
      9'd144: r = 17'h62f2; 9'd145: r = 17'h6371; 9'd146: r = 17'h63ef; 9'd147: r = 17'h646c;
      9'd148: r = 17'h64e8; 9'd149: r = 17'h6563; 9'd150: r = 17'h65dd; 9'd151: r = 17'h6657;
      9'd152: r = 17'h66cf; 9'd153: r = 17'h6746; 9'd154: r = 17'h67bd; 9'd155: r = 17'h6832;
      9'd156: r = 17'h68a6; 9'd157: r = 17'h6919; 9'd158: r = 17'h698c; 9'd159: r = 17'h69fd;
      9'd160: r = 17'h6a6d; 9'd161: r = 17'h6adc; 9'd162: r = 17'h6b4a; 9'd163: r = 17'h6bb8;
      9'd164: r = 17'h6c24; 9'd165: r = 17'h6c8f; 9'd166: r = 17'h6cf9; 9'd167: r = 17'h6d62;
      9'd168: r = 17'h6dca; 9'd169: r = 17'h6e30; 9'd170: r = 17'h6e96; 9'd171: r = 17'h6efb;
      9'd172: r = 17'h6f5f; 9'd173: r = 17'h6fc1; 9'd174: r = 17'h7023; 9'd175: r = 17'h7083;
      9'd176: r = 17'h70e2; 9'd177: r = 17'h7141; 9'd178: r = 17'h719e; 9'd179: r = 17'h71fa;
      9'd180: r = 17'h7255; 9'd181: r = 17'h72af; 9'd182: r = 17'h7307; 9'd183: r = 17'h735f;
      9'd184: r = 17'h73b5; 9'd185: r = 17'h740b; 9'd186: r = 17'h745f; 9'd187: r = 17'h74b2;
      9'd188: r = 17'h7504; 9'd189: r = 17'h7555; 9'd190: r = 17'h75a5; 9'd191: r = 17'h75f4;
      9'd192: r = 17'h7641; 9'd193: r = 17'h768e; 9'd194: r = 17'h76d9; 9'd195: r = 17'h7723;
      9'd196: r = 17'h776c; 9'd197: r = 17'h77b4; 9'd198: r = 17'h77fa; 9'd199: r = 17'h7840;
      9'd200: r = 17'h7884; 9'd201: r = 17'h78c7; 9'd202: r = 17'h7909; 9'd203: r = 17'h794a;
      9'd204: r = 17'h798a; 9'd205: r = 17'h79c8; 9'd206: r = 17'h7a05; 9'd207: r = 17'h7a42;
      9'd208: r = 17'h7a7d; 9'd209: r = 17'h7ab6; 9'd210: r = 17'h7aef; 9'd211: r = 17'h7b26;
      9'd212: r = 17'h7b5d; 9'd213: r = 17'h7b92; 9'd214: r = 17'h7bc5; 9'd215: r = 17'h7bf8;
      9'd216: r = 17'h7c29; 9'd217: r = 17'h7c5a; 9'd218: r = 17'h7c89; 9'd219: r = 17'h7cb7;
      9'd220: r = 17'h7ce3; 9'd221: r = 17'h7d0f; 9'd222: r = 17'h7d39; 9'd223: r = 17'h7d62;
      9'd224: r = 17'h7d8a; 9'd225: r = 17'h7db0; 9'd226: r = 17'h7dd6; 9'd227: r = 17'h7dfa;
      9'd228: r = 17'h7e1d; 9'd229: r = 17'h7e3f; 9'd230: r = 17'h7e5f; 9'd231: r = 17'h7e7f;
      9'd232: r = 17'h7e9d; 9'd233: r = 17'h7eba; 9'd234: r = 17'h7ed5; 9'd235: r = 17'h7ef0;
      9'd236: r = 17'h7f09; 9'd237: r = 17'h7f21; 9'd238: r = 17'h7f38; 9'd239: r = 17'h7f4d;
      9'd240: r = 17'h7f62; 9'd241: r = 17'h7f75; 9'd242: r = 17'h7f87; 9'd243: r = 17'h7f97;
      9'd244: r = 17'h7fa7; 9'd245: r = 17'h7fb5; 9'd246: r = 17'h7fc2; 9'd247: r = 17'h7fce;
      9'd248: r = 17'h7fd8; 9'd249: r = 17'h7fe1; 9'd250: r = 17'h7fe9; 9'd251: r = 17'h7ff0;
      9'd252: r = 17'h7ff6; 9'd253: r = 17'h7ffa; 9'd254: r = 17'h7ffd; 9'd255: r = 17'h7fff;
      9'd256: r = 17'h8000;
      default: r = 17'h8000;
    endcase
    return r;
  endfunction
endpackage

[design/scti_lerp.sv]
// Linear interpolation between two ROM entries with floor shift by the fraction width.
`timescale 1ns / 1ps
module scti_lerp (
  input  logic [16:0]           base,
  input  logic [16:0]           next,
  input  scti_pkg::frac_t       frac,
  output logic signed [16:0]    value
);
  import scti_pkg::*;
  logic signed [17:0] diff;
  logic signed [24:0] prod;
  logic signed [18:0] shifted;
  logic signed [18:0] sum;

  assign diff    = $signed({1'b0, next}) - $signed({1'b0, base});
  assign prod    = diff * $signed({1'b0, frac});
  // arithmetic right shift is floor division by 64
  assign shifted = 19'(prod >>> FracW);
  assign sum     = $signed({2'b00, base}) + shifted;
  assign value   = sum[16:0];
endmodule

[design/sine_cosine_table_interpolator_core.sv]
// Top level: sine and cosine of a 16-bit angle from a quarter-wave ROM.
// Results appear on sine_value/cosine_value with done high in the cycle
// after start is taken (one register stage after the combinational datapath).
// Throughput: one angle per clock; busy is always low, and the receiver cannot
// stall. The rate is set by the four ROM lookups plus two multipliers.
// Reset (rst, synchronous, active high) clears the done strobe only.
`timescale 1ns / 1ps
module sine_cosine_table_interpolator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  scti_pkg::angle_t    angle,
  output logic                done,
  output scti_pkg::trig_t     sine_value,
  output scti_pkg::trig_t     cosine_value
);
  import scti_pkg::*;

  logic [1:0]  quad;
  logic [15:0] fold;      // folded angle, always 0..16384
  logic [16:0] fold_w;
  logic        neg_s;
  logic        neg_c;
  rom_idx_t    idx;
  frac_t       frac;
  rom_idx_t    sidx_next;
  rom_idx_t    cidx;
  rom_idx_t    cidx_next;
  logic signed [16:0] s_mag;
  logic signed [16:0] c_mag;
  trig_t       sine_next;
  trig_t       cosine_next;

  // No back pressure: a new transaction can enter every cycle.
  assign busy = 1'b0;

  // Quadrant from the top bits of the angle offset by half a turn.
  assign quad = angle[15:14] ^ 2'b10;

  // Fold into the first quadrant; the widened form keeps 16384 exact.
  always_comb begin
    fold_w = 17'd0;
    neg_s  = 1'b0;
    neg_c  = 1'b0;
    case (quad)
      2'd2: begin
        fold_w = {1'b0, angle};
      end
      2'd3: begin
        fold_w = 17'h08000 - {1'b0, angle};
        neg_c  = 1'b1;
      end
      2'd0: begin
        fold_w = 17'h08000 + {angle[15], angle};
        neg_s  = 1'b1;
        neg_c  = 1'b1;
      end
      default: begin
        fold_w = 17'd0 - {angle[15], angle};
        neg_s  = 1'b1;
      end
    endcase
  end

  assign fold = fold_w[15:0];
  assign idx  = fold[14:6];
  assign frac = fold[5:0];

  // Neighbor entries; at full quarter the fraction is zero so the next entry is unused.
  assign sidx_next = (idx < 9'(RomLast)) ? idx + 9'd1 : 9'(RomLast);
  assign cidx      = 9'(RomLast) - idx;
  assign cidx_next = (idx < 9'(RomLast)) ? cidx - 9'd1 : 9'd0;

  scti_lerp u_sin (
    .base  (rom_entry(idx)),
    .next  (rom_entry(sidx_next)),
    .frac  (frac),
    .value (s_mag)
  );

  scti_lerp u_cos (
    .base  (rom_entry(cidx)),
    .next  (rom_entry(cidx_next)),
    .frac  (frac),
    .value (c_mag)
  );

  // Apply quadrant signs.
  assign sine_next   = neg_s ? -s_mag : s_mag;
  assign cosine_next = neg_c ? -c_mag : c_mag;

  // Result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      sine_value   <= sine_next;
      cosine_value <= cosine_next;
    end
  end

  // Strobe in the cycle after each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    start |=> done) else $error("done missing after start");
  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !start |=> !done) else $error("done without start");
  a_magnitude: assert property (@(posedge clk) disable iff (rst)
    done |-> (sine_value <= 17'sd32768 && sine_value >= -17'sd32768 &&
              cosine_value <= 17'sd32768 && cosine_value >= -17'sd32768))
    else $error("result out of range");
`endif
endmodule

[sim/testbench.sv]
// Testbench for the sine/cosine table interpolator: random and directed angles vs. a local predictor.
`timescale 1ns / 1ps
module testbench;
  import scti_pkg::*;

  // Quarter-wave sine in Q15, entries 0..256.
  localparam int QuarterSine [0:256] = '{
    'h0000,'h00c9,'h0192,'h025b,'h0324,'h03ed,'h04b6,'h057f,
    'h0647,'h0710,'h07d9,'h08a2,'h096a,'h0a33,'h0afb,'h0bc3,
    'h0c8b,'h0d53,'h0e1b,'h0ee3,'h0fab,'h1072,'h1139,'h1201,
    'h12c8,'h138e,'h1455,'h151b,'h15e2,'h16a8,'h176d,'h1833,
    'h18f8,'h19bd,'h1a82,'h1b47,'h1c0b,'h1ccf,'h1d93,'h1e56,
    'h1f19,'h1fdc,'h209f,'h2161,'h2223,'h22e5,'h23a6,'h2467,
    'h2528,'h25e8,'h26a8,'h2767,'h2826,'h28e5,'h29a3,'h2a61,
    'h2b1f,'h2bdc,'h2c98,'h2d55,'h2e11,'h2ecc,'h2f87,'h3041,
    'h30fb,'h31b5,'h326e,'h3326,'h33de,'h3496,'h354d,'h3604,
    'h36ba,'h376f,'h3824,'h38d8,'h398c,'h3a40,'h3af2,'h3ba5,
    'h3c56,'h3d07,'h3db8,'h3e68,'h3f17,'h3fc5,'h4073,'h4121,
    'h41ce,'h427a,'h4325,'h43d0,'h447a,'h4524,'h45cd,'h4675,
    'h471c,'h47c3,'h4869,'h490f,'h49b4,'h4a58,'h4afb,'h4b9e,
    'h4c3f,'h4ce1,'h4d81,'h4e21,'h4ebf,'h4f5e,'h4ffb,'h5097,
    'h5133,'h51ce,'h5269,'h5302,'h539b,'h5433,'h54ca,'h5560,
    'h55f5,'h568a,'h571d,'h57b0,'h5842,'h58d4,'h5964,'h59f3,
    'h5a82,'h5b10,'h5b9d,'h5c29,'h5cb4,'h5d3e,'h5dc7,'h5e50,
    'h5ed7,'h5f5e,'h5fe3,'h6068,'h60ec,'h616f,'h61f1,'h6271,
    'h62f2,'h6371,'h63ef,'h646c,'h64e8,'h6563,'h65dd,'h6657,
    'h66cf,'h6746,'h67bd,'h6832,'h68a6,'h6919,'h698c,'h69fd,
    'h6a6d,'h6adc,'h6b4a,'h6bb8,'h6c24,'h6c8f,'h6cf9,'h6d62,
    'h6dca,'h6e30,'h6e96,'h6efb,'h6f5f,'h6fc1,'h7023,'h7083,
    'h70e2,'h7141,'h719e,'h71fa,'h7255,'h72af,'h7307,'h735f,
    'h73b5,'h740b,'h745f,'h74b2,'h7504,'h7555,'h75a5,'h75f4,
    'h7641,'h768e,'h76d9,'h7723,'h776c,'h77b4,'h77fa,'h7840,
    'h7884,'h78c7,'h7909,'h794a,'h798a,'h79c8,'h7a05,'h7a42,
    'h7a7d,'h7ab6,'h7aef,'h7b26,'h7b5d,'h7b92,'h7bc5,'h7bf8,
    'h7c29,'h7c5a,'h7c89,'h7cb7,'h7ce3,'h7d0f,'h7d39,'h7d62,
    'h7d8a,'h7db0,'h7dd6,'h7dfa,'h7e1d,'h7e3f,'h7e5f,'h7e7f,
    'h7e9d,'h7eba,'h7ed5,'h7ef0,'h7f09,'h7f21,'h7f38,'h7f4d,
    'h7f62,'h7f75,'h7f87,'h7f97,'h7fa7,'h7fb5,'h7fc2,'h7fce,
    'h7fd8,'h7fe1,'h7fe9,'h7ff0,'h7ff6,'h7ffa,'h7ffd,'h7fff,
    'h8000};

  typedef struct packed {
    trig_t sine;
    trig_t cosine;
  } trig_pair_t;

  class trig_scoreboard;
    trig_pair_t pending[$];
    int         errors;

    function int interp(int base, int next, int frac);
      int p;
      p = frac * (next - base);
      return base + ((p >= 0) ? (p >>> 6) : -(((-p) + 63) >>> 6));
    endfunction

    // Fold into the first quadrant, interpolate, then apply quadrant signs.
    function trig_pair_t predict(angle_t a);
      int ai, f, idx, frac, s, c;
      logic [1:0] quad;
      trig_pair_t r;
      ai = int'(a);
      quad = 2'((int'({1'b0, a}) + 'h8000) >> 14);
      case (quad)
        2'd2: f = ai;
        2'd3: f = 32768 - ai;
        2'd0: f = 32768 + ai;
        default: f = -ai;
      endcase
      idx = f >> 6;
      frac = f & 63;
      s = interp(QuarterSine[idx], QuarterSine[(idx < 256) ? idx + 1 : 256], frac);
      c = interp(QuarterSine[256 - idx], QuarterSine[(idx < 256) ? 255 - idx : 0], frac);
      if (quad == 2'd0 || quad == 2'd1) s = -s;
      if (quad == 2'd0 || quad == 2'd3) c = -c;
      r.sine = trig_t'(s);
      r.cosine = trig_t'(c);
      return r;
    endfunction

    function void note_angle(angle_t a);
      pending.push_back(predict(a));
    endfunction

    function void check_result(trig_t s, trig_t c);
      trig_pair_t e;
      if (pending.size() == 0) begin
        $error("unexpected result sine_value=%0d cosine_value=%0d", s, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (s !== e.sine) begin
        $error("sine_value expected %0d actual %0d", e.sine, s);
        errors++;
      end
      if (c !== e.cosine) begin
        $error("cosine_value expected %0d actual %0d", e.cosine, c);
        errors++;
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  angle_t angle = '0;
  logic   busy, done;
  trig_t  sine_value, cosine_value;
  int     cycles = 0;
  bit     quiet = 1'b0;
  trig_scoreboard sb = new();

  localparam int CycleLimit = 200000;

  sine_cosine_table_interpolator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .angle(angle),
    .done(done), .sine_value(sine_value), .cosine_value(cosine_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted transactions and check results at each rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && start && !busy) sb.note_angle(angle);
    if (!rst && done) sb.check_result(sine_value, cosine_value);
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive one angle, idling at random first unless in a quiet stretch.
  task automatic send_angle(angle_t a);
    while (!quiet && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    angle <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Directed angles: quadrant edges, full quarter, the -180 code, interpolation steps.
  angle_t directed [] = '{
    16'sh0000, 16'sh0001, 16'sh003f, 16'sh0040, 16'sh3fff, 16'sh4000, 16'sh4001,
    16'sh7fff, 16'sh8000, 16'sh8001, 16'shbfff, 16'shc000, 16'shc001, 16'shffff,
    16'sh2000, 16'shdfff, 16'sh5555, 16'shaaaa, 16'sh1041, 16'sh6fbf, 16'sh00ff};

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_angle(directed[i]);
    // Hold off until every expected result has come.
    drain();
    for (int n = 0; n < 750; n++) begin
      quiet = (n >= 300 && n < 420);
      case ($urandom_range(3))
        0: send_angle(angle_t'($urandom_range(3) << 14) + angle_t'($urandom_range(2) - 1));
        1: send_angle(angle_t'($urandom_range(1023) << 6));
        default: send_angle(angle_t'($urandom()));
      endcase
    end
    drain();
    repeat (5) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[sine_cosine_table_interpolator_core.f]
design/scti_pkg.sv
design/scti_lerp.sv
design/sine_cosine_table_interpolator_core.sv
sim/testbench.sv
